// File: design/cbts_pkg.sv
// ----------------------------------------------------------------------------
// CAN bit timing search package
// Shared widths and constants for the bit timing search and its divider.
// ----------------------------------------------------------------------------
package cbts_pkg;

  localparam int DIV_W = 28;

  localparam logic [27:0] CLK_RESET = 28'd80000000;

  localparam logic [27:0] RATE_FAST = 28'd800000;
  localparam logic [27:0] RATE_MID  = 28'd500000;

  localparam logic [9:0] TARGET_FAST = 10'd750;
  localparam logic [9:0] TARGET_MID  = 10'd800;
  localparam logic [9:0] TARGET_SLOW = 10'd875;

  localparam logic [4:0] TOTAL_MAX = 5'd25;
  localparam logic [4:0] TOTAL_MIN = 5'd3;
  localparam logic [4:0] SMP_MIN   = 5'd2;
  localparam logic [4:0] SMP_MAX   = 5'd17;
  localparam logic [4:0] S2_MAX    = 5'd8;

  localparam logic [27:0] PRESC_MAX = 28'd16384;
  localparam logic [14:0] ROUND     = 15'd500;
  localparam logic [9:0]  PER_MILLE = 10'd1000;

endpackage

// File: design/cbts_div.sv
// ----------------------------------------------------------------------------
// CAN bit timing divider
// Restoring unsigned divider, one quotient bit per cycle, with a done pulse.
// ----------------------------------------------------------------------------
module cbts_div #(
  parameter int WIDTH = cbts_pkg::DIV_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [WIDTH-1:0] quotient,
  output logic [WIDTH-1:0] remainder
);

  localparam int CNT_W = $clog2(WIDTH);

  logic [WIDTH-1:0] quo_r, rem_r, dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [WIDTH:0]   rem_sh;
  logic [WIDTH+1:0] trial;
  logic             ge;

  assign rem_sh = {rem_r, quo_r[WIDTH-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dvs_r};
  assign ge     = ~trial[WIDTH+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(WIDTH - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[WIDTH-2:0], ge};
      rem_r <= ge ? trial[WIDTH-1:0] : rem_sh[WIDTH-1:0];
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// File: design/can_bit_timing_search.sv
// ----------------------------------------------------------------------------
// CAN bit timing search
// Finds prescaler, segments and jump width for a requested CAN bitrate.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy then stays high
// until the result is out. Every division runs on the single 28-bit
// divider, which produces one quotient bit per cycle and does every division
// of the search. A zero bitrate, or one that does not divide the source
// clock, returns after the first division. Otherwise the block divides once
// more for each quanta count from 25 down to 3, plus one more for each count
// that yields a usable prescaler and another when its sample point also fits.
// The result shows on the out_ ports for one cycle, marked by out_valid; the
// receiver cannot stall it, so it must take it in that cycle.
// The source clock register is written over APB at addresses 0 to 3; the user
// must write it only while busy is low, as the block itself does not enforce it.
module can_bit_timing_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [27:0] in_bitrate,
  output logic        out_valid,
  output logic        out_failed,
  output logic [14:0] out_timing_word0,
  output logic [6:0]  out_timing_word1
);

  localparam int W = cbts_pkg::DIV_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;

  localparam logic [1:0] P_CLK = 2'd0;
  localparam logic [1:0] P_Q   = 2'd1;
  localparam logic [1:0] P_SMP = 2'd2;
  localparam logic [1:0] P_ACT = 2'd3;

  logic [27:0] clk_hz_r;
  logic [1:0]  state_r, state_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [27:0] rate_r, rate_nxt;
  logic [27:0] per_bit_r, per_bit_nxt;
  logic [4:0]  total_r, total_nxt;
  logic [9:0]  target_r, target_nxt;
  logic [14:0] q_r, q_nxt;
  logic [4:0]  smp_r, smp_nxt;
  logic        found_r, found_nxt;
  logic [9:0]  best_err_r, best_err_nxt;
  logic [12:0] best_qh_r, best_qh_nxt;
  logic [3:0]  best_s1_r, best_s1_nxt;
  logic [3:0]  best_s2_r, best_s2_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_failed_r, out_failed_nxt;
  logic [14:0] word0_r, word0_nxt;
  logic [6:0]  word1_r, word1_nxt;

  logic         div_start, div_busy, div_done;
  logic [W-1:0] div_dvd, div_dvs, div_quot, div_rem;

  logic         accept;
  logic [14:0]  smp_prod;
  logic [4:0]   smp_c, s2_c;
  logic [9:0]   act_c, err_c;
  logic [13:0]  qh_c;
  logic         adv;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {4'b0, clk_hz_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_hz_r <= cbts_pkg::CLK_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      clk_hz_r <= pwdata[27:0];
    end
  end

  cbts_div #(.WIDTH(W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    rate_nxt       = rate_r;
    per_bit_nxt    = per_bit_r;
    total_nxt      = total_r;
    target_nxt     = target_r;
    q_nxt          = q_r;
    smp_nxt        = smp_r;
    found_nxt      = found_r;
    best_err_nxt   = best_err_r;
    best_qh_nxt    = best_qh_r;
    best_s1_nxt    = best_s1_r;
    best_s2_nxt    = best_s2_r;
    out_valid_nxt  = 1'b0;
    out_failed_nxt = out_failed_r;
    word0_nxt      = word0_r;
    word1_nxt      = word1_r;
    div_start      = 1'b0;
    div_dvd        = '0;
    div_dvs        = '0;
    adv            = 1'b0;

    smp_prod = 15'(total_r * target_r) + cbts_pkg::ROUND;
    smp_c    = (div_quot > W'(cbts_pkg::SMP_MAX)) ? cbts_pkg::SMP_MAX :
               (div_quot < W'(cbts_pkg::SMP_MIN)) ? cbts_pkg::SMP_MIN : div_quot[4:0];
    s2_c     = total_r - smp_c;
    act_c    = div_quot[9:0];
    err_c    = (act_c > target_r) ? act_c - target_r : target_r - act_c;
    qh_c     = q_r[14:1] - 14'd1;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RUN;
          phase_nxt = P_CLK;
          rate_nxt  = in_bitrate;
          found_nxt = 1'b0;
          div_start = 1'b1;
          div_dvd   = clk_hz_r;
          div_dvs   = in_bitrate;
          if (in_bitrate >= cbts_pkg::RATE_FAST) begin
            target_nxt = cbts_pkg::TARGET_FAST;
          end else if (in_bitrate >= cbts_pkg::RATE_MID) begin
            target_nxt = cbts_pkg::TARGET_MID;
          end else begin
            target_nxt = cbts_pkg::TARGET_SLOW;
          end
        end
      end
      S_RUN: begin
        if (div_done) begin
          case (phase_r)
            P_CLK: begin
              if (rate_r == '0 || div_rem != '0) begin
                state_nxt      = S_IDLE;
                out_valid_nxt  = 1'b1;
                out_failed_nxt = 1'b1;
                word0_nxt      = '0;
                word1_nxt      = '0;
              end else begin
                per_bit_nxt = div_quot;
                total_nxt   = cbts_pkg::TOTAL_MAX;
                phase_nxt   = P_Q;
                div_start   = 1'b1;
                div_dvd     = div_quot;
                div_dvs     = W'(cbts_pkg::TOTAL_MAX);
              end
            end
            P_Q: begin
              if (div_rem == '0 && !div_quot[0] && div_quot != '0 &&
                  div_quot <= cbts_pkg::PRESC_MAX) begin
                q_nxt     = div_quot[14:0];
                phase_nxt = P_SMP;
                div_start = 1'b1;
                div_dvd   = W'(smp_prod);
                div_dvs   = W'(cbts_pkg::PER_MILLE);
              end else begin
                adv = 1'b1;
              end
            end
            P_SMP: begin
              if (smp_c < total_r && s2_c <= cbts_pkg::S2_MAX) begin
                smp_nxt   = smp_c;
                phase_nxt = P_ACT;
                div_start = 1'b1;
                div_dvd   = W'(15'(smp_c * cbts_pkg::PER_MILLE));
                div_dvs   = W'(total_r);
              end else begin
                adv = 1'b1;
              end
            end
            P_ACT: begin
              if (!found_r || err_c < best_err_r) begin
                found_nxt    = 1'b1;
                best_err_nxt = err_c;
                best_qh_nxt  = qh_c[12:0];
                best_s1_nxt  = 4'(smp_r - 5'd1);
                best_s2_nxt  = 4'(total_r - smp_r);
              end
              adv = 1'b1;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
        if (adv) begin
          if (total_r == cbts_pkg::TOTAL_MIN) begin
            state_nxt      = S_IDLE;
            out_valid_nxt  = 1'b1;
            out_failed_nxt = !found_nxt;
            if (found_nxt) begin
              word0_nxt = {(best_s2_nxt >= 4'd2), 1'b0, best_qh_nxt};
              word1_nxt = {3'(best_s2_nxt - 4'd1), 4'(best_s1_nxt - 4'd1)};
            end else begin
              word0_nxt = '0;
              word1_nxt = '0;
            end
          end else begin
            total_nxt = total_r - 5'd1;
            phase_nxt = P_Q;
            div_start = 1'b1;
            div_dvd   = per_bit_r;
            div_dvs   = W'(total_r - 5'd1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= P_CLK;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rate_r       <= rate_nxt;
    per_bit_r    <= per_bit_nxt;
    total_r      <= total_nxt;
    target_r     <= target_nxt;
    q_r          <= q_nxt;
    smp_r        <= smp_nxt;
    best_err_r   <= best_err_nxt;
    best_qh_r    <= best_qh_nxt;
    best_s1_r    <= best_s1_nxt;
    best_s2_r    <= best_s2_nxt;
    out_failed_r <= out_failed_nxt;
    word0_r      <= word0_nxt;
    word1_r      <= word1_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_failed       = out_failed_r;
  assign out_timing_word0 = word0_r;
  assign out_timing_word1 = word1_r;

  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_failed) |-> (out_timing_word0 == '0 && out_timing_word1 == '0))
    else $error("failed result carries nonzero timing words");

  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_busy)
    else $error("divider running while sequencer idle");

  a_ok_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_failed) |-> (out_timing_word0[13] == 1'b0))
    else $error("reserved timing bit set");

endmodule
